// ----- rtl/ref_pkg.sv -----
// ----------------------------------------------------------------------------
// ref_pkg: shared definitions for the redundant edge finder
// Table sizing, label widths and result outcome codes.
// ----------------------------------------------------------------------------
package ref_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LABEL_W   = 7;
    localparam int OUTCOME_W = 2;

    localparam logic [LABEL_W-1:0] NODE_COUNT_RESET = 7'd64;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_FOUND    = 2'd0,
        OUTCOME_NO_CYCLE = 2'd1,
        OUTCOME_FAULT    = 2'd2
    } t_outcome;

endpackage

// ----- rtl/ref_ram.sv -----
// ----------------------------------------------------------------------------
// ref_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ref_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/redundant_edge_finder_core.sv -----
// ----------------------------------------------------------------------------
// redundant_edge_finder_core: union-find redundant edge detector
// An edge item accepted in S_IDLE walks from its first label to the root
// (S_FIND_A), then from its second label (S_FIND_B), and ends in S_FINISH;
// depth is the number of parent hops to the root (0..MAX_NODES-1), and the
// root walk takes one hop a cycle through the single parent RAM read port.
// No new item is taken before S_IDLE; an item with a bad label or after a loop
// skips the walks. A final item also waits while an earlier result is stalled.
// Reset (synchronous, active low) empties the table and sets node_count to 64.
// ----------------------------------------------------------------------------
module redundant_edge_finder_core
    import ref_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_node_count_we,
    input  logic [LABEL_W-1:0]   i_node_count,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [LABEL_W-1:0]   i_edge_first,
    input  logic [LABEL_W-1:0]   i_edge_second,
    input  logic                 i_last_edge,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [LABEL_W-1:0]   o_redundant_first,
    output logic [LABEL_W-1:0]   o_redundant_second,
    output logic [OUTCOME_W-1:0] o_outcome
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FIND_A = 4'b0010,
        S_FIND_B = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [LABEL_W-1:0]   r_node_count;
    logic [LABEL_W-1:0]   r_a, n_a, r_b, n_b;
    logic                 r_last, n_last;
    logic [NODE_W-1:0]    r_cur, n_cur;
    logic [NODE_W-1:0]    r_root_a, n_root_a;
    logic [MAX_NODES-1:0] r_valid, n_valid;
    logic                 r_cycle, n_cycle;
    logic                 r_fault, n_fault;
    logic [LABEL_W-1:0]   r_saved_first, n_saved_first;
    logic [LABEL_W-1:0]   r_saved_second, n_saved_second;
    logic                 r_out_valid, n_out_valid;
    logic [LABEL_W-1:0]   r_out_first, n_out_first;
    logic [LABEL_W-1:0]   r_out_second, n_out_second;
    t_outcome             r_outcome, n_outcome;

    logic              accept;
    logic              labels_ok;
    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr;
    logic [NODE_W-1:0] ram_wdata;
    logic [NODE_W-1:0] ram_rdata;
    logic [NODE_W-1:0] parent;

    function automatic logic label_ok(input logic [LABEL_W-1:0] lbl,
                                      input logic [LABEL_W-1:0] cnt);
        return (lbl != '0) && (lbl <= cnt) && (int'(lbl) <= MAX_NODES);
    endfunction

    ref_ram #(
        .WIDTH(NODE_W),
        .DEPTH(MAX_NODES)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_cur),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign labels_ok  = label_ok(i_edge_first, r_node_count)
                     && label_ok(i_edge_second, r_node_count);

    // an entry never written points to itself
    assign parent = r_valid[r_cur] ? ram_rdata : r_cur;

    always_comb begin
        n_state        = r_state;
        n_a            = r_a;
        n_b            = r_b;
        n_last         = r_last;
        n_cur          = r_cur;
        n_root_a       = r_root_a;
        n_valid        = r_valid;
        n_cycle        = r_cycle;
        n_fault        = r_fault;
        n_saved_first  = r_saved_first;
        n_saved_second = r_saved_second;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_first    = r_out_first;
        n_out_second   = r_out_second;
        n_outcome      = r_outcome;
        ram_we         = 1'b0;
        ram_waddr      = r_root_a;
        ram_wdata      = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_a    = i_edge_first;
                    n_b    = i_edge_second;
                    n_last = i_last_edge;
                    if (!labels_ok) begin
                        n_fault = 1'b1;
                        n_state = S_FINISH;
                    end else if (r_cycle) begin
                        n_state = S_FINISH;
                    end else begin
                        n_cur   = NODE_W'(i_edge_first - LABEL_W'(1));
                        n_state = S_FIND_A;
                    end
                end
            end
            S_FIND_A: begin
                if (parent == r_cur) begin
                    n_root_a = r_cur;
                    n_cur    = NODE_W'(r_b - LABEL_W'(1));
                    n_state  = S_FIND_B;
                end else begin
                    n_cur = parent;
                end
            end
            S_FIND_B: begin
                if (parent == r_cur) begin
                    if (r_root_a == r_cur) begin
                        n_cycle        = 1'b1;
                        n_saved_first  = r_a;
                        n_saved_second = r_b;
                    end else begin
                        // hang root of a under root of b
                        ram_we             = 1'b1;
                        n_valid[r_root_a]  = 1'b1;
                    end
                    n_state = S_FINISH;
                end else begin
                    n_cur = parent;
                end
            end
            S_FINISH: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    if (r_fault) begin
                        n_out_first  = '0;
                        n_out_second = '0;
                        n_outcome    = OUTCOME_FAULT;
                    end else if (r_cycle) begin
                        n_out_first  = r_saved_first;
                        n_out_second = r_saved_second;
                        n_outcome    = OUTCOME_FOUND;
                    end else begin
                        n_out_first  = '0;
                        n_out_second = '0;
                        n_outcome    = OUTCOME_NO_CYCLE;
                    end
                    // drop the graph for the next one
                    n_valid        = '0;
                    n_cycle        = 1'b0;
                    n_fault        = 1'b0;
                    n_saved_first  = '0;
                    n_saved_second = '0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_node_count   <= NODE_COUNT_RESET;
            r_valid        <= '0;
            r_cycle        <= 1'b0;
            r_fault        <= 1'b0;
            r_saved_first  <= '0;
            r_saved_second <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            if (i_node_count_we) begin
                r_node_count <= i_node_count;
            end
            r_valid        <= n_valid;
            r_cycle        <= n_cycle;
            r_fault        <= n_fault;
            r_saved_first  <= n_saved_first;
            r_saved_second <= n_saved_second;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a          <= n_a;
        r_b          <= n_b;
        r_last       <= n_last;
        r_cur        <= n_cur;
        r_root_a     <= n_root_a;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_outcome    <= n_outcome;
    end

    assign o_out_valid        = r_out_valid;
    assign o_redundant_first  = r_out_first;
    assign o_redundant_second = r_out_second;
    assign o_outcome          = r_outcome;

endmodule

// ----- bench/redundant_edge_finder_core_test.sv -----
// ----------------------------------------------------------------------------
// redundant_edge_finder_core_test: self-checking bench for the edge finder
// Drives graphs edge by edge: a short directed table, then random graphs
// (trees closed by one extra edge, forests, bad labels and noise) under
// several node counts. A union-find predictor in the bench computes each
// untyped graph's result, and every result item is checked field by field.
// ----------------------------------------------------------------------------
module redundant_edge_finder_core_test;
    import ref_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 2 * MAX_NODES + 24;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 150;
    localparam int RANDOM_COUNT  = -1;

    typedef struct packed {
        logic [LABEL_W-1:0] node_a;
        logic [LABEL_W-1:0] node_b;
        t_outcome           outcome;
    } t_verdict;

    typedef struct packed {
        logic [LABEL_W-1:0] node_a;
        logic [LABEL_W-1:0] node_b;
        logic               is_last;
        logic               typed;
        t_verdict           want;
    } t_edge;

    localparam t_verdict NO_VERDICT = '{7'd0, 7'd0, OUTCOME_FOUND};
    localparam t_verdict BAD_LABEL  = '{7'd0, 7'd0, OUTCOME_FAULT};
    localparam t_verdict ACYCLIC    = '{7'd0, 7'd0, OUTCOME_NO_CYCLE};

    logic                 i_clk;
    logic                 i_rst_n            = 1'b0;
    logic                 i_node_count_we    = 1'b0;
    logic [LABEL_W-1:0]   i_node_count       = NODE_COUNT_RESET;
    logic                 i_in_valid         = 1'b0;
    logic                 o_in_stall;
    logic [LABEL_W-1:0]   i_edge_first       = '0;
    logic [LABEL_W-1:0]   i_edge_second      = '0;
    logic                 i_last_edge        = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall        = 1'b0;
    logic [LABEL_W-1:0]   o_redundant_first;
    logic [LABEL_W-1:0]   o_redundant_second;
    logic [OUTCOME_W-1:0] o_outcome;

    // typed expectation travels with the item it belongs to
    logic                 drv_typed = 1'b0;
    t_verdict             drv_want  = NO_VERDICT;

    // union-find predictor state
    logic [NODE_W-1:0]    link_table [MAX_NODES];
    logic                 loop_seen;
    logic [LABEL_W-1:0]   kept_a;
    logic [LABEL_W-1:0]   kept_b;
    logic                 bad_label;
    logic [LABEL_W-1:0]   cfg_nodes;

    t_verdict             verdicts_due [$];
    int                   fails         = 0;
    int                   results_done  = 0;
    int                   quiet_cycles  = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    t_edge plan_rows [0:21] = '{
        '{7'd1,   7'd2,   1'b0, 1'b0, NO_VERDICT},
        '{7'd2,   7'd3,   1'b0, 1'b0, NO_VERDICT},
        '{7'd1,   7'd3,   1'b1, 1'b1, '{7'd1, 7'd3, OUTCOME_FOUND}},
        '{7'd5,   7'd5,   1'b1, 1'b1, '{7'd5, 7'd5, OUTCOME_FOUND}},
        '{7'd1,   7'd64,  1'b1, 1'b1, ACYCLIC},
        '{7'd0,   7'd3,   1'b1, 1'b1, BAD_LABEL},
        '{7'd65,  7'd1,   1'b0, 1'b0, NO_VERDICT},
        '{7'd1,   7'd2,   1'b1, 1'b1, BAD_LABEL},
        '{7'd127, 7'd127, 1'b1, 1'b1, BAD_LABEL},
        '{7'd3,   7'd4,   1'b0, 1'b0, NO_VERDICT},
        '{7'd4,   7'd3,   1'b0, 1'b0, NO_VERDICT},
        '{7'd64,  7'd63,  1'b0, 1'b0, NO_VERDICT},
        '{7'd63,  7'd64,  1'b1, 1'b1, '{7'd4, 7'd3, OUTCOME_FOUND}},
        '{7'd64,  7'd1,   1'b0, 1'b0, NO_VERDICT},
        '{7'd1,   7'd64,  1'b1, 1'b1, '{7'd1, 7'd64, OUTCOME_FOUND}},
        '{7'd2,   7'd2,   1'b0, 1'b0, NO_VERDICT},
        '{7'd100, 7'd1,   1'b1, 1'b1, BAD_LABEL},
        '{7'd7,   7'd9,   1'b0, 1'b0, NO_VERDICT},
        '{7'd9,   7'd11,  1'b0, 1'b0, NO_VERDICT},
        '{7'd11,  7'd7,   1'b1, 1'b0, NO_VERDICT},
        '{7'd20,  7'd30,  1'b0, 1'b0, NO_VERDICT},
        '{7'd30,  7'd20,  1'b1, 1'b0, NO_VERDICT}
    };

    redundant_edge_finder_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_node_count_we    (i_node_count_we),
        .i_node_count       (i_node_count),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_edge_first       (i_edge_first),
        .i_edge_second      (i_edge_second),
        .i_last_edge        (i_last_edge),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_redundant_first  (o_redundant_first),
        .o_redundant_second (o_redundant_second),
        .o_outcome          (o_outcome)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int find_root(input int v);
        int hop;
        for (hop = 0; hop < MAX_NODES; hop++) begin
            if (int'(link_table[v % MAX_NODES]) == v) break;
            v = int'(link_table[v % MAX_NODES]);
        end
        return v;
    endfunction

    task automatic wipe_graph();
        for (int k = 0; k < MAX_NODES; k++) link_table[k] = NODE_W'(k);
        loop_seen = 1'b0;
        kept_a    = '0;
        kept_b    = '0;
        bad_label = 1'b0;
    endtask

    task automatic absorb_edge(input t_edge e, output bit emits, output t_verdict v);
        int lim;
        int ra;
        int rb;
        lim   = (int'(cfg_nodes) > MAX_NODES) ? MAX_NODES : int'(cfg_nodes);
        emits = 1'b0;
        v     = NO_VERDICT;
        if (e.node_a == 0 || e.node_b == 0 || int'(e.node_a) > lim || int'(e.node_b) > lim) begin
            bad_label = 1'b1;
        end else if (!loop_seen) begin
            ra = find_root(int'(e.node_a) - 1);
            rb = find_root(int'(e.node_b) - 1);
            if (ra == rb) begin
                loop_seen = 1'b1;
                kept_a    = e.node_a;
                kept_b    = e.node_b;
            end else begin
                link_table[ra % MAX_NODES] = NODE_W'(rb);
            end
        end
        if (e.is_last) begin
            emits = 1'b1;
            if (bad_label) v = BAD_LABEL;
            else if (loop_seen) v = '{kept_a, kept_b, OUTCOME_FOUND};
            else v = ACYCLIC;
            wipe_graph();
        end
    endtask

    // scoreboard, predictor update and watchdog
    always @(posedge i_clk) begin
        t_verdict calc;
        t_verdict want;
        t_edge    taken;
        bit       emits;
        bit       moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            wipe_graph();
            cfg_nodes = NODE_COUNT_RESET;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                results_done++;
                if (verdicts_due.size() == 0) begin
                    $error("result with nothing expected: %0d %0d outcome %0d",
                           o_redundant_first, o_redundant_second, o_outcome);
                    fails++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_redundant_first !== want.node_a) begin
                        $error("redundant_first: expected %0d, got %0d",
                               want.node_a, o_redundant_first);
                        fails++;
                    end
                    if (o_redundant_second !== want.node_b) begin
                        $error("redundant_second: expected %0d, got %0d",
                               want.node_b, o_redundant_second);
                        fails++;
                    end
                    if (o_outcome !== want.outcome) begin
                        $error("outcome: expected %0d, got %0d", want.outcome, o_outcome);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved         = 1'b1;
                taken.node_a  = i_edge_first;
                taken.node_b  = i_edge_second;
                taken.is_last = i_last_edge;
                taken.typed   = drv_typed;
                taken.want    = drv_want;
                absorb_edge(taken, emits, calc);
                if (emits) begin
                    verdicts_due.insert(verdicts_due.size(), drv_typed ? drv_want : calc);
                end
            end
            if (i_node_count_we) cfg_nodes = i_node_count;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stall, plus long hold-offs that back the block up
    initial begin
        int hold_marks [3];
        int next_hold;
        hold_marks = '{8, 70, 160};
        next_hold  = 0;
        forever begin
            @(posedge i_clk);
            if (next_hold < 3 && results_done >= hold_marks[next_hold]) begin
                next_hold++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // valid is never lowered and raised in one step: gaps lower it first
    task automatic push_edge(input t_edge e);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_edge_first  <= e.node_a;
        i_edge_second <= e.node_b;
        i_last_edge   <= e.is_last;
        drv_typed     <= e.typed;
        drv_want      <= e.want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // hold the input until every result is in, then let the block go idle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_nodes(input int count);
        i_node_count_we <= 1'b1;
        i_node_count    <= LABEL_W'(count);
        @(posedge i_clk);
        i_node_count_we <= 1'b0;
    endtask

    task automatic send_graph(input int lim, inout int sent);
        t_edge hops [$];
        t_edge e;
        t_edge tmp;
        int    labels [$];
        int    kind;
        int    k;
        int    cap;
        int    i;
        int    j;
        int    n;
        int    pick;
        int    t;
        bit    chain;
        kind = $urandom_range(99);
        e    = '0;
        if (lim == 0 || kind < 10) begin
            // noise: labels anywhere in the field
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
                e.node_a = LABEL_W'($urandom_range(0, 127));
                e.node_b = LABEL_W'($urandom_range(0, 127));
                hops.insert(hops.size(), e);
            end
        end else begin
            cap = (lim < 10) ? lim : 10;
            k   = ($urandom_range(9) == 0) ? lim : $urandom_range(1, cap);
            for (i = 1; i <= lim; i++) labels.insert(labels.size(), i);
            for (i = lim - 1; i > 0; i--) begin
                j         = $urandom_range(i);
                t         = labels[i];
                labels[i] = labels[j];
                labels[j] = t;
            end
            chain = ($urandom_range(3) == 0);
            for (i = 1; i < k; i++) begin
                j = chain ? i - 1 : $urandom_range(i - 1);
                if ($urandom_range(1)) begin
                    e.node_a = LABEL_W'(labels[i]);
                    e.node_b = LABEL_W'(labels[j]);
                end else begin
                    e.node_a = LABEL_W'(labels[j]);
                    e.node_b = LABEL_W'(labels[i]);
                end
                hops.insert(hops.size(), e);
            end
            // close the tree with one extra edge, unless a forest is wanted
            if (!(kind < 20 && k > 1)) begin
                e.node_a = LABEL_W'(labels[$urandom_range(k - 1)]);
                e.node_b = LABEL_W'(labels[$urandom_range(k - 1)]);
                hops.insert($urandom_range(hops.size()), e);
            end
            if (!chain) begin
                for (i = hops.size() - 1; i > 0; i--) begin
                    j       = $urandom_range(i);
                    tmp     = hops[i];
                    hops[i] = hops[j];
                    hops[j] = tmp;
                end
            end
            if (kind >= 20 && kind < 26) begin
                pick = $urandom_range(hops.size() - 1);
                t    = $urandom_range(1) ? 0 : $urandom_range(lim + 1, 127);
                if ($urandom_range(1)) hops[pick].node_a = LABEL_W'(t);
                else hops[pick].node_b = LABEL_W'(t);
            end
        end
        for (i = 0; i < hops.size(); i++) begin
            tmp         = hops[i];
            tmp.is_last = (i == hops.size() - 1);
            push_edge(tmp);
        end
        sent += hops.size();
    endtask

    initial begin
        int cfg_plan [12];
        int count;
        int lim;
        int sent;
        cfg_plan = '{1, 64, 0, 127, 2, 10, 64, RANDOM_COUNT, 33, 127, 5, 64};
        send_idle_pct  = 25;
        recv_stall_pct = 62;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        program_nodes(64);
        foreach (plan_rows[r]) push_edge(plan_rows[r]);
        for (int stage = 0; stage < 3; stage++) begin
            send_idle_pct  = (stage == 0) ? 25 : (stage == 1) ? 62 : 0;
            recv_stall_pct = (stage == 0) ? 62 : (stage == 1) ? 25 : 0;
            for (int ph = 0; ph < 4; ph++) begin
                drain();
                count = cfg_plan[stage * 4 + ph];
                if (count == RANDOM_COUNT) count = $urandom_range(1, 64);
                program_nodes(count);
                lim  = (count > MAX_NODES) ? MAX_NODES : count;
                sent = 0;
                while (sent < PHASE_ITEMS) begin
                    send_graph(lim, sent);
                    if ($urandom_range(14) == 0) drain();
                end
            end
        end
        drain();
        if (fails == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ref_pkg.sv
rtl/ref_ram.sv
rtl/redundant_edge_finder_core.sv
bench/redundant_edge_finder_core_test.sv
